// File: hw/rtl/cfta_pkg.sv
// Shared types and constants for the cube map face and texel address pipeline.
package cfta_pkg;

	localparam int COORD_WIDTH_DEF   = 16;
	localparam int MAX_FACE_SIZE_DEF = 4096;

	// Configuration port layout.
	localparam int CFG_DATA_W  = 13;
	localparam int CFG_INDEX_W = 1;
	localparam logic [CFG_DATA_W-1:0] SIZE_RESET = 13'd512;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_FACE_WIDTH  = 1'b0,
		REG_FACE_HEIGHT = 1'b1
	} cfta_reg_t;

	typedef enum logic [2:0] {
		FACE_POS_X = 3'd0,
		FACE_NEG_X = 3'd1,
		FACE_POS_Y = 3'd2,
		FACE_NEG_Y = 3'd3,
		FACE_POS_Z = 3'd4,
		FACE_NEG_Z = 3'd5
	} cfta_face_t;

	// Per-word side information that rides along with the divider lanes.
	typedef struct packed {
		cfta_face_t face;
		logic       zero;
	} cfta_tag_t;

endpackage

// File: hw/rtl/cubemap_face_texel_address.sv
// Cube map face selection and texel addressing: direction vector in, face and texel out.
// Pipeline: $clog2(MAX_FACE_SIZE) + 6 register stages (18 by default).
// Throughput: one word per clock while not stalled; the divider advances one quotient bit per stage.
// A stalled output parks one word in a skid entry; input stalls only once that is full.
// Reset (arst_n low, asynchronous) empties the pipeline and sets both face sizes to 512.
module cubemap_face_texel_address import cfta_pkg::*; #(
	parameter int COORD_WIDTH   = COORD_WIDTH_DEF,
	parameter int MAX_FACE_SIZE = MAX_FACE_SIZE_DEF,
	localparam int OUT_W        = $clog2(MAX_FACE_SIZE)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [CFG_INDEX_W-1:0]        cfg_index,
	input  logic [CFG_DATA_W-1:0]         cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [COORD_WIDTH-1:0] dir_x,
	input  logic signed [COORD_WIDTH-1:0] dir_y,
	input  logic signed [COORD_WIDTH-1:0] dir_z,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [2:0]                    face,
	output logic [OUT_W-1:0]              texel_col,
	output logic [OUT_W-1:0]              texel_row,
	output logic                          zero_vector
);

	// The quotient can equal the face size, so it carries one more bit than a
	// texel index. The divisor is twice the major magnitude.
	localparam int SIZE_W = $clog2(MAX_FACE_SIZE) + 1;
	localparam int DEN_W  = COORD_WIDTH + 2;
	localparam int NUM_W  = DEN_W + SIZE_W;

	// Configuration registers. Writes must arrive only while the pipeline is empty;
	// the block does not enforce this. Given that, every stage may read them directly.
	logic [CFG_DATA_W-1:0] width_q, height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= SIZE_RESET;
			height_q <= SIZE_RESET;
		end else if (cfg_wr_en) begin
			case (cfta_reg_t'(cfg_index))
				REG_FACE_WIDTH:  width_q  <= cfg_data;
				REG_FACE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sizes above the supported maximum saturate to it.
	logic [SIZE_W-1:0] width_size, height_size;

	always_comb begin
		width_size  = (32'(width_q) > 32'(MAX_FACE_SIZE)) ? SIZE_W'(MAX_FACE_SIZE)
		                                                  : SIZE_W'(width_q);
		height_size = (32'(height_q) > 32'(MAX_FACE_SIZE)) ? SIZE_W'(MAX_FACE_SIZE)
		                                                   : SIZE_W'(height_q);
	end

	// The whole pipeline moves together; it halts only while the skid entry
	// in the output stage is occupied.
	logic en;
	assign in_ready = en;

	logic             front_valid;
	logic [NUM_W-1:0] num_u, num_v;
	logic [DEN_W-1:0] den;
	cfta_tag_t        front_tag;

	cfta_front #(
		.COORD_WIDTH (COORD_WIDTH),
		.SIZE_W      (SIZE_W)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.in_valid    (in_valid),
		.dir_x       (dir_x),
		.dir_y       (dir_y),
		.dir_z       (dir_z),
		.width_size  (width_size),
		.height_size (height_size),
		.out_valid   (front_valid),
		.num_u       (num_u),
		.num_v       (num_v),
		.den         (den),
		.tag         (front_tag)
	);

	logic              div_valid;
	logic [SIZE_W-1:0] quo_u, quo_v;
	cfta_tag_t         div_tag;

	cfta_div #(
		.DEN_W (DEN_W),
		.QUO_W (SIZE_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (front_valid),
		.num_u     (num_u),
		.num_v     (num_v),
		.den       (den),
		.in_tag    (front_tag),
		.out_valid (div_valid),
		.quo_u     (quo_u),
		.quo_v     (quo_v),
		.out_tag   (div_tag)
	);

	cfta_out #(
		.QUO_W (SIZE_W),
		.OUT_W (OUT_W)
	) u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.ready       (en),
		.in_valid    (div_valid),
		.quo_u       (quo_u),
		.quo_v       (quo_v),
		.in_tag      (div_tag),
		.width_size  (width_size),
		.height_size (height_size),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.face        (face),
		.texel_col   (texel_col),
		.texel_row   (texel_row),
		.zero_vector (zero_vector)
	);

endmodule

// File: hw/rtl/cfta_front.sv
// Front stages: magnitudes, major axis selection, offsets and size multiplication.
module cfta_front import cfta_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int SIZE_W      = $clog2(MAX_FACE_SIZE_DEF) + 1,
	localparam int MAG_W      = COORD_WIDTH + 1,
	localparam int SUM_W      = COORD_WIDTH + 2,
	localparam int NUM_W      = SUM_W + SIZE_W
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic signed [COORD_WIDTH-1:0] dir_x,
	input  logic signed [COORD_WIDTH-1:0] dir_y,
	input  logic signed [COORD_WIDTH-1:0] dir_z,
	input  logic        [SIZE_W-1:0]      width_size,
	input  logic        [SIZE_W-1:0]      height_size,
	output logic                          out_valid,
	output logic        [NUM_W-1:0]       num_u,
	output logic        [NUM_W-1:0]       num_v,
	output logic        [SUM_W-1:0]       den,
	output cfta_tag_t                     tag
);

	// Stage 1: registered direction and its magnitudes.
	logic                          valid_s1;
	logic signed [COORD_WIDTH-1:0] x_s1, y_s1, z_s1;
	logic        [MAG_W-1:0]       ax_s1, ay_s1, az_s1;
	logic signed [MAG_W-1:0]       xe, ye, ze;

	always_comb begin
		xe = MAG_W'(dir_x);
		ye = MAG_W'(dir_y);
		ze = MAG_W'(dir_z);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1  <= dir_x;
			y_s1  <= dir_y;
			z_s1  <= dir_z;
			ax_s1 <= xe[MAG_W-1] ? MAG_W'(-xe) : MAG_W'(xe);
			ay_s1 <= ye[MAG_W-1] ? MAG_W'(-ye) : MAG_W'(ye);
			az_s1 <= ze[MAG_W-1] ? MAG_W'(-ze) : MAG_W'(ze);
		end
	end

	// Stage 2: major axis, face and face-local coordinates.
	logic                    valid_s2;
	logic        [MAG_W-1:0] ma_s2;
	logic signed [MAG_W-1:0] sc_s2, tc_s2;
	cfta_tag_t               tag_s2;

	logic        [MAG_W-1:0] ma_c;
	logic signed [MAG_W-1:0] sc_c, tc_c, x1e, y1e, z1e;
	cfta_face_t              face_c;
	logic                    x_pos, y_pos, z_pos;

	always_comb begin
		x1e   = MAG_W'(x_s1);
		y1e   = MAG_W'(y_s1);
		z1e   = MAG_W'(z_s1);
		x_pos = !x_s1[COORD_WIDTH-1] && (x_s1 != '0);
		y_pos = !y_s1[COORD_WIDTH-1] && (y_s1 != '0);
		z_pos = !z_s1[COORD_WIDTH-1] && (z_s1 != '0);
		if (ax_s1 > ay_s1 && ax_s1 > az_s1) begin
			ma_c = ax_s1;
			tc_c = y1e;
			if (x_pos) begin
				face_c = FACE_POS_X;
				sc_c   = z1e;
			end else begin
				face_c = FACE_NEG_X;
				sc_c   = MAG_W'(-z1e);
			end
		end else if (ay_s1 > az_s1) begin
			ma_c = ay_s1;
			sc_c = x1e;
			if (y_pos) begin
				face_c = FACE_POS_Y;
				tc_c   = z1e;
			end else begin
				face_c = FACE_NEG_Y;
				tc_c   = MAG_W'(-z1e);
			end
		end else begin
			ma_c = az_s1;
			tc_c = y1e;
			if (z_pos) begin
				face_c = FACE_POS_Z;
				sc_c   = MAG_W'(-x1e);
			end else begin
				face_c = FACE_NEG_Z;
				sc_c   = x1e;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ma_s2       <= ma_c;
			sc_s2       <= sc_c;
			tc_s2       <= tc_c;
			tag_s2.face <= face_c;
			tag_s2.zero <= (ma_c == '0);
		end
	end

	// Stage 3: shift the coordinates into the range zero to twice the major magnitude.
	logic             valid_s3;
	logic [SUM_W-1:0] su_s3, sv_s3, den_s3;
	cfta_tag_t        tag_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			su_s3  <= SUM_W'(sc_s2) + SUM_W'(ma_s2);
			sv_s3  <= SUM_W'(tc_s2) + SUM_W'(ma_s2);
			den_s3 <= {ma_s2, 1'b0};
			tag_s3 <= tag_s2;
		end
	end

	// Stage 4: scale by the face size to form the dividends.
	logic             valid_s4;
	logic [NUM_W-1:0] nu_s4, nv_s4;
	logic [SUM_W-1:0] den_s4;
	cfta_tag_t        tag_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nu_s4  <= NUM_W'(su_s3) * NUM_W'(width_size);
			nv_s4  <= NUM_W'(sv_s3) * NUM_W'(height_size);
			den_s4 <= den_s3;
			tag_s4 <= tag_s3;
		end
	end

	assign out_valid = valid_s4;
	assign num_u     = nu_s4;
	assign num_v     = nv_s4;
	assign den       = den_s4;
	assign tag       = tag_s4;

endmodule

// File: hw/rtl/cfta_div.sv
// Two-lane restoring divider, one quotient bit per pipeline stage, shared divisor.
module cfta_div import cfta_pkg::*; #(
	parameter int DEN_W = COORD_WIDTH_DEF + 2,
	parameter int QUO_W = $clog2(MAX_FACE_SIZE_DEF) + 1,
	localparam int NUM_W = DEN_W + QUO_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  logic [NUM_W-1:0] num_u,
	input  logic [NUM_W-1:0] num_v,
	input  logic [DEN_W-1:0] den,
	input  cfta_tag_t        in_tag,
	output logic             out_valid,
	output logic [QUO_W-1:0] quo_u,
	output logic [QUO_W-1:0] quo_v,
	output cfta_tag_t        out_tag
);

	// Each stage holds the partial remainder and a word whose upper part is the
	// numerator still to be consumed and whose lower part is the quotient so far.
	// The quotient is known to fit in QUO_W bits, so the upper numerator bits
	// already form a remainder below the divisor.
	logic             valid_s [QUO_W];
	logic [DEN_W-1:0] rem_u_s [QUO_W];
	logic [DEN_W-1:0] rem_v_s [QUO_W];
	logic [QUO_W-1:0] nq_u_s  [QUO_W];
	logic [QUO_W-1:0] nq_v_s  [QUO_W];
	logic [DEN_W-1:0] den_s   [QUO_W];
	cfta_tag_t        tag_s   [QUO_W];

	for (genvar i = 0; i < QUO_W; i++) begin : g_step
		logic             cur_valid;
		logic [DEN_W-1:0] cur_rem_u, cur_rem_v, cur_den;
		logic [QUO_W-1:0] cur_nq_u, cur_nq_v;
		cfta_tag_t        cur_tag;
		logic [DEN_W:0]   tu, tv;
		logic             gu, gv;

		if (i == 0) begin : g_first
			always_comb begin
				cur_valid = in_valid;
				cur_rem_u = num_u[NUM_W-1:QUO_W];
				cur_rem_v = num_v[NUM_W-1:QUO_W];
				cur_nq_u  = num_u[QUO_W-1:0];
				cur_nq_v  = num_v[QUO_W-1:0];
				cur_den   = den;
				cur_tag   = in_tag;
			end
		end else begin : g_next
			always_comb begin
				cur_valid = valid_s[i-1];
				cur_rem_u = rem_u_s[i-1];
				cur_rem_v = rem_v_s[i-1];
				cur_nq_u  = nq_u_s[i-1];
				cur_nq_v  = nq_v_s[i-1];
				cur_den   = den_s[i-1];
				cur_tag   = tag_s[i-1];
			end
		end

		always_comb begin
			tu = {cur_rem_u, cur_nq_u[QUO_W-1]};
			tv = {cur_rem_v, cur_nq_v[QUO_W-1]};
			gu = (tu >= {1'b0, cur_den});
			gv = (tv >= {1'b0, cur_den});
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[i] <= 1'b0;
			end else if (en) begin
				valid_s[i] <= cur_valid;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_u_s[i] <= gu ? DEN_W'(tu - {1'b0, cur_den}) : tu[DEN_W-1:0];
				rem_v_s[i] <= gv ? DEN_W'(tv - {1'b0, cur_den}) : tv[DEN_W-1:0];
				nq_u_s[i]  <= {cur_nq_u[QUO_W-2:0], gu};
				nq_v_s[i]  <= {cur_nq_v[QUO_W-2:0], gv};
				den_s[i]   <= cur_den;
				tag_s[i]   <= cur_tag;
			end
		end
	end

	assign out_valid = valid_s[QUO_W-1];
	assign quo_u     = nq_u_s[QUO_W-1];
	assign quo_v     = nq_v_s[QUO_W-1];
	assign out_tag   = tag_s[QUO_W-1];

endmodule

// File: hw/rtl/cfta_out.sv
// Result fixup (wrap at face size, zero vector) and output register with skid entry.
module cfta_out import cfta_pkg::*; #(
	parameter int QUO_W = $clog2(MAX_FACE_SIZE_DEF) + 1,
	parameter int OUT_W = $clog2(MAX_FACE_SIZE_DEF)
) (
	input  logic             clk,
	input  logic             arst_n,
	output logic             ready,
	input  logic             in_valid,
	input  logic [QUO_W-1:0] quo_u,
	input  logic [QUO_W-1:0] quo_v,
	input  cfta_tag_t        in_tag,
	input  logic [QUO_W-1:0] width_size,
	input  logic [QUO_W-1:0] height_size,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [2:0]       face,
	output logic [OUT_W-1:0] texel_col,
	output logic [OUT_W-1:0] texel_row,
	output logic             zero_vector
);

	typedef struct packed {
		cfta_face_t face;
		logic [OUT_W-1:0] col;
		logic [OUT_W-1:0] row;
		logic zero;
	} res_t;

	res_t res_c, out_q, skid_q;
	logic out_valid_q, skid_valid_q, push;

	// The quotient never exceeds the size, so only equality needs the wrap.
	always_comb begin
		res_c.face = in_tag.face;
		res_c.zero = in_tag.zero;
		res_c.col  = (in_tag.zero || quo_u == width_size) ? '0 : OUT_W'(quo_u);
		res_c.row  = (in_tag.zero || quo_v == height_size) ? '0 : OUT_W'(quo_v);
	end

	assign ready = !skid_valid_q;
	assign push  = in_valid && ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			out_valid_q  <= skid_valid_q || push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || out_ready) begin
			out_q <= skid_valid_q ? skid_q : res_c;
		end else if (push) begin
			skid_q <= res_c;
		end
	end

	assign out_valid   = out_valid_q;
	assign face        = out_q.face;
	assign texel_col   = out_q.col;
	assign texel_row   = out_q.row;
	assign zero_vector = out_q.zero;

endmodule
